FILE: sv/tvp_pkg.sv
package tvp_pkg;

   // message length limit and derived counter widths
   localparam int MAX_MESSAGE_BYTES = 1024;
   localparam int CNT_W             = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int IDX_W             = 10;
   localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_MESSAGE_BYTES - 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic [3:0] CMD_U64 = 4'd7;
   localparam logic [3:0] CMD_F16 = 4'd8;
   localparam logic [3:0] CMD_F32 = 4'd9;
   localparam logic [3:0] CMD_F64 = 4'd10;

   // byte count codes (number of bytes is 2**code)
   localparam logic [1:0] SIZE_1 = 2'd0;
   localparam logic [1:0] SIZE_2 = 2'd1;
   localparam logic [1:0] SIZE_4 = 2'd2;
   localparam logic [1:0] SIZE_8 = 2'd3;

   // one classified item, word left aligned so the first byte sits on top
   typedef struct packed {
      logic [63:0] word;
      logic [1:0]  size;
      logic        has_bytes;
      logic        err;
      logic        eom;
   } entry_type;

endpackage

FILE: sv/tvp_front.sv
module tvp_front (
   input  logic [3:0]          req_command,
   input  logic [63:0]         req_value,
   input  logic                req_end_of_message,
   output tvp_pkg::entry_type  entry
);
   import tvp_pkg::*;

   logic        s32;
   logic [7:0]  e32;
   logic [22:0] f32;
   logic        s64;
   logic [10:0] e64;
   logic [51:0] f64;
   logic [34:0] frac_prod;
   logic [10:0] frac16;
   logic [4:0]  ex16;
   logic [15:0] word16;
   logic        err16;
   logic [31:0] word32;
   logic        err32;
   logic [63:0] word64;
   logic        err64;
   logic [63:0] raw;

   // single and double fields
   assign s32 = req_value[31];
   assign e32 = req_value[30:23];
   assign f32 = req_value[22:0];
   assign s64 = req_value[63];
   assign e64 = req_value[62:52];
   assign f64 = req_value[51:0];

   // f16 fraction: floor(f * 2049 / 2**24) as shift and add
   assign frac_prod = {1'b0, f32, 11'b0} + {12'b0, f32};
   assign frac16    = frac_prod[34:24];
   assign ex16      = 5'(e32 - 8'd112);

   // single to half with repair
   always_comb begin
      err16  = 1'b1;
      word16 = {s32, 15'b0};
      if (e32 == 8'd0 && f32 == 23'd0) begin
         err16  = 1'b0;
         word16 = 16'd0;
      end else if (e32 == 8'hFF || e32 >= 8'd143) begin
         word16 = {s32, 5'h1F, 10'b0};
      end else if (e32 <= 8'd112) begin
         word16 = {s32, 15'b0};
      end else begin
         err16  = 1'b0;
         word16 = {s32, ex16, 10'b0} | {5'b0, frac16};
      end
   end

   // single pass-through with repair
   always_comb begin
      err32  = 1'b1;
      word32 = {s32, 31'b0};
      if (e32 == 8'd0 && f32 == 23'd0) begin
         err32  = 1'b0;
         word32 = 32'd0;
      end else if (e32 == 8'hFF) begin
         word32 = {s32, 8'hFF, 23'b0};
      end else if (e32 != 8'd0) begin
         err32  = 1'b0;
         word32 = req_value[31:0];
      end
   end

   // double pass-through with repair
   always_comb begin
      err64  = 1'b1;
      word64 = {s64, 63'b0};
      if (e64 == 11'd0 && f64 == 52'd0) begin
         err64  = 1'b0;
         word64 = 64'd0;
      end else if (e64 == 11'h7FF) begin
         word64 = {s64, 11'h7FF, 52'b0};
      end else if (e64 != 11'd0) begin
         err64  = 1'b0;
         word64 = req_value;
      end
   end

   // classify the command
   always_comb begin
      entry.eom       = req_end_of_message;
      entry.has_bytes = 1'b1;
      entry.err       = 1'b0;
      entry.size      = req_command[1:0];
      raw             = req_value;
      priority if (req_command <= CMD_U64) begin
         raw = req_value;
      end else if (req_command == CMD_F16) begin
         entry.size = SIZE_2;
         entry.err  = err16;
         raw        = {48'b0, word16};
      end else if (req_command == CMD_F32) begin
         entry.size = SIZE_4;
         entry.err  = err32;
         raw        = {32'b0, word32};
      end else if (req_command == CMD_F64) begin
         entry.size = SIZE_8;
         entry.err  = err64;
         raw        = word64;
      end else begin
         entry.has_bytes = 1'b0;
         entry.size      = SIZE_1;
      end
   end

   // left align so the most significant byte leads
   always_comb begin
      unique case (entry.size)
         SIZE_1:  entry.word = {raw[7:0], 56'b0};
         SIZE_2:  entry.word = {raw[15:0], 48'b0};
         SIZE_4:  entry.word = {raw[31:0], 32'b0};
         SIZE_8:  entry.word = raw;
         default: entry.word = raw;
      endcase
   end

endmodule

FILE: sv/tvp_queue.sv
module tvp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  tvp_pkg::entry_type  wr_data,
   output logic                full,
   input  logic                rd_en,
   output tvp_pkg::entry_type  rd_data,
   output logic                empty
);
   import tvp_pkg::*;

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // fill count within depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   // count follows the transfers
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a write");

endmodule

FILE: sv/tvp_back.sv
module tvp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tvp_pkg::entry_type      head,
   input  logic                    head_valid,
   output logic                    head_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_byte,
   output logic [tvp_pkg::IDX_W-1:0] rsp_byte_index,
   output logic                    rsp_range_error,
   output logic                    rsp_message_overflow
);
   import tvp_pkg::*;

   logic              busy_ff, busy_in;
   logic [63:0]       word_ff, word_in;
   logic [2:0]        left_ff, left_in;
   logic              err_ff, err_in;
   logic              eom_ff, eom_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_err_ff, out_err_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              advance;
   logic              emit;
   logic              skip;
   logic              sat;
   logic [63:0]       cur_word;
   logic [2:0]        cur_left;
   logic              cur_err;
   logic              cur_eom;
   logic [2:0]        head_left;

   // bytes remaining after the first, from the size code
   always_comb begin
      unique case (head.size)
         SIZE_1:  head_left = 3'd0;
         SIZE_2:  head_left = 3'd1;
         SIZE_4:  head_left = 3'd3;
         SIZE_8:  head_left = 3'd7;
         default: head_left = 3'd0;
      endcase
   end

   // work from the item in flight or straight from the queue head
   assign cur_word = busy_ff ? word_ff : head.word;
   assign cur_left = busy_ff ? left_ff : head_left;
   assign cur_err  = busy_ff ? err_ff  : head.err;
   assign cur_eom  = busy_ff ? eom_ff  : head.eom;

   assign advance  = !out_valid_ff || rsp_pop;
   assign emit     = advance && (busy_ff || (head_valid && head.has_bytes));
   assign skip     = !busy_ff && head_valid && !head.has_bytes;
   assign head_pop = !busy_ff && head_valid && (!head.has_bytes || emit);
   assign sat      = (count_ff >= CNT_W'(MAX_MESSAGE_BYTES));

   // serializer and message counter
   always_comb begin
      busy_in      = busy_ff;
      word_in      = word_ff;
      left_in      = left_ff;
      err_in       = err_ff;
      eom_in       = eom_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_idx_in   = out_idx_ff;
      out_err_in   = out_err_ff;
      out_ovf_in   = out_ovf_ff;
      if (advance) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_word[63:56];
         out_last_in  = (cur_left == 3'd0);
         out_idx_in   = sat ? IDX_SAT : count_ff[IDX_W-1:0];
         out_err_in   = cur_err;
         out_ovf_in   = sat;
         busy_in      = (cur_left != 3'd0);
         word_in      = {cur_word[55:0], 8'b0};
         left_in      = cur_left - 3'd1;
         err_in       = cur_err;
         eom_in       = cur_eom;
         if (cur_left == 3'd0 && cur_eom) begin
            count_in = '0;
         end else if (!sat) begin
            count_in = count_ff + 1'b1;
         end
      end else if (skip && head.eom) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      left_ff     <= left_in;
      err_ff      <= err_in;
      eom_ff      <= eom_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_idx_ff  <= out_idx_in;
      out_err_ff  <= out_err_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_empty            = !out_valid_ff;
   assign rsp_out_byte         = out_byte_ff;
   assign rsp_last_byte        = out_last_ff;
   assign rsp_byte_index       = out_idx_ff;
   assign rsp_range_error      = out_err_ff;
   assign rsp_message_overflow = out_ovf_ff;

   // counter never passes the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MESSAGE_BYTES))
      else $error("byte counter beyond message limit");

   // overflowed bytes carry the saturated index
   a_ovf_index: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_message_overflow) |-> (rsp_byte_index == IDX_SAT))
      else $error("overflow byte with unsaturated index");

   // a shown byte that is not last leaves an item in flight
   a_mid_item: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> busy_ff)
      else $error("item dropped before its last byte");

endmodule

FILE: sv/typed_value_packer_core.sv
// a transfer in is written into the queue, then its first byte is registered in the output stage
// throughput: one byte per cycle unless the receiver stalls; an item sends its 1, 2, 4 or 8 bytes
// from the serializer in turn, and an invalid code is popped there and emits nothing
// a four-entry queue lets input transfers continue while the serializer drains
// reset: synchronous, active high; clears queue, serializer, output stage and byte counter
module typed_value_packer_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [3:0]                req_command,
   input  logic [63:0]               req_value,
   input  logic                      req_end_of_message,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_byte,
   output logic [tvp_pkg::IDX_W-1:0] rsp_byte_index,
   output logic                      rsp_range_error,
   output logic                      rsp_message_overflow
);
   import tvp_pkg::*;

   entry_type  front_entry;
   entry_type  head_entry;
   logic       head_empty;
   logic       head_pop;

   // classify and convert
   tvp_front u_front (
      .req_command        (req_command),
      .req_value          (req_value),
      .req_end_of_message (req_end_of_message),
      .entry              (front_entry)
   );

   // decoupling queue
   tvp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push),
      .wr_data (front_entry),
      .full    (req_full),
      .rd_en   (head_pop),
      .rd_data (head_entry),
      .empty   (head_empty)
   );

   // byte serializer
   tvp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head_entry),
      .head_valid           (!head_empty),
      .head_pop             (head_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last_byte        (rsp_last_byte),
      .rsp_byte_index       (rsp_byte_index),
      .rsp_range_error      (rsp_range_error),
      .rsp_message_overflow (rsp_message_overflow)
   );

endmodule

FILE: bench/typed_value_packer_checker.sv
module typed_value_packer_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic                      req_full,
   input  logic [3:0]                req_command,
   input  logic [63:0]               req_value,
   input  logic                      req_end_of_message,
   input  logic                      rsp_empty,
   input  logic                      rsp_pop,
   input  logic [7:0]                rsp_out_byte,
   input  logic                      rsp_last_byte,
   input  logic [tvp_pkg::IDX_W-1:0] rsp_byte_index,
   input  logic                      rsp_range_error,
   input  logic                      rsp_message_overflow,
   output int                        mismatches,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import tvp_pkg::*;

   // float format geometry
   localparam int unsigned F16_EBITS = 5;
   localparam int unsigned F16_MBITS = 10;
   localparam int unsigned F32_EBITS = 8;
   localparam int unsigned F32_MBITS = 23;
   localparam int unsigned F64_EBITS = 11;
   localparam int unsigned F64_MBITS = 52;
   localparam int unsigned F32_EONES = 8'hFF;
   localparam int unsigned F64_EONES = 11'h7FF;
   localparam int          F32_BIAS  = 127;
   localparam int          F64_BIAS  = 1023;
   // half fraction scale (2^10 + 0.5) / 2^23 in fixed point
   localparam logic [63:0] F16_FRAC_MUL   = 64'd2049;
   localparam int unsigned F16_FRAC_SHIFT = 24;

   typedef struct {
      logic [7:0]       data;
      logic             last;
      logic [IDX_W-1:0] index;
      logic             err;
      logic             ovf;
   } packed_byte_type;

   packed_byte_type  byte_queue[$];
   logic [CNT_W-1:0] msg_bytes;
   int               fail_total  = 0;
   int               queued_bytes = 0;
   int               checked      = 0;

   assign mismatches  = fail_total;
   assign outstanding = queued_bytes;

   task automatic report(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      fail_total++;
   endtask

   // rebias one float into the target format, repairing what does not fit
   function automatic logic [63:0] fold_float(input logic sgn, input int unsigned e,
                                              input logic [63:0] f,
                                              input int unsigned in_ones, input int in_bias,
                                              input int unsigned ebits, input int unsigned mbits,
                                              input logic [63:0] sig, output logic err);
      int unsigned out_ones;
      int          out_bias;
      logic [63:0] sbit;
      logic [63:0] inf;
      int          ex;
      out_ones = (1 << ebits) - 1;
      out_bias = (1 << (ebits - 1)) - 1;
      sbit     = 64'(sgn) << (ebits + mbits);
      inf      = sbit | (64'(out_ones) << mbits);
      err      = 1'b0;
      if (e == 0 && f == 0)
         return 64'd0;
      if (e == in_ones) begin
         err = 1'b1;
         return inf;
      end
      if (e == 0) begin
         err = 1'b1;
         return sbit;
      end
      ex = int'(e) - in_bias + out_bias;
      if (ex <= 0) begin
         err = 1'b1;
         return sbit;
      end
      if (ex >= int'(out_ones)) begin
         err = 1'b1;
         return inf;
      end
      return sbit | (64'(ex) << mbits) | sig;
   endfunction

   // word to serialize, its byte count and the repair flag for one command
   function automatic void pack_value(input logic [3:0] cmd, input logic [63:0] v,
                                      output logic [63:0] word, output int nbytes,
                                      output logic err);
      word   = 64'd0;
      nbytes = 0;
      err    = 1'b0;
      if (cmd <= CMD_U64) begin
         nbytes = 1 << cmd[1:0];
         word   = v;
      end else if (cmd == CMD_F16) begin
         nbytes = 2;
         word   = fold_float(v[31], 32'(v[30:23]), 64'(v[22:0]), F32_EONES, F32_BIAS,
                             F16_EBITS, F16_MBITS,
                             (64'(v[22:0]) * F16_FRAC_MUL) >> F16_FRAC_SHIFT, err);
      end else if (cmd == CMD_F32) begin
         nbytes = 4;
         word   = fold_float(v[31], 32'(v[30:23]), 64'(v[22:0]), F32_EONES, F32_BIAS,
                             F32_EBITS, F32_MBITS, 64'(v[22:0]), err);
      end else if (cmd == CMD_F64) begin
         nbytes = 8;
         word   = fold_float(v[63], 32'(v[62:52]), 64'(v[51:0]), F64_EONES, F64_BIAS,
                             F64_EBITS, F64_MBITS, 64'(v[51:0]), err);
      end
   endfunction

   // compare result transfers, then queue the bytes of each input transfer
   always @(posedge clock) begin
      packed_byte_type want;
      logic [63:0]     word;
      int              nbytes;
      logic            err;
      if (reset) begin
         byte_queue.delete();
         msg_bytes = '0;
         queued_bytes <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (byte_queue.size() == 0) begin
               report($sformatf("unexpected byte %h index %0d", rsp_out_byte, rsp_byte_index));
            end else begin
               want = byte_queue.pop_front();
               if (rsp_out_byte !== want.data)
                  report($sformatf("byte %0d out_byte %h, want %h",
                                   checked, rsp_out_byte, want.data));
               if (rsp_last_byte !== want.last)
                  report($sformatf("byte %0d last_byte %b, want %b",
                                   checked, rsp_last_byte, want.last));
               if (rsp_byte_index !== want.index)
                  report($sformatf("byte %0d byte_index %0d, want %0d",
                                   checked, rsp_byte_index, want.index));
               if (rsp_range_error !== want.err)
                  report($sformatf("byte %0d range_error %b, want %b",
                                   checked, rsp_range_error, want.err));
               if (rsp_message_overflow !== want.ovf)
                  report($sformatf("byte %0d message_overflow %b, want %b",
                                   checked, rsp_message_overflow, want.ovf));
            end
            checked++;
         end
         if (req_push && !req_full) begin
            pack_value(req_command, req_value, word, nbytes, err);
            for (int k = 0; k < nbytes; k++) begin
               want.data = 8'(word >> (8 * (nbytes - 1 - k)));
               want.last = (k == nbytes - 1);
               want.err  = err;
               // index saturates once the message is full
               if (msg_bytes >= MAX_MESSAGE_BYTES) begin
                  want.index = IDX_SAT;
                  want.ovf   = 1'b1;
               end else begin
                  want.index = msg_bytes[IDX_W-1:0];
                  want.ovf   = 1'b0;
                  msg_bytes++;
               end
               byte_queue.push_back(want);
            end
            if (req_end_of_message)
               msg_bytes = '0;
         end
         queued_bytes <= byte_queue.size();
      end
   end

endmodule

FILE: bench/typed_value_packer_core_tb.sv
module typed_value_packer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tvp_pkg::*;

   // integer and invalid command codes not named in the package
   localparam logic [3:0] CMD_S8        = 4'd0;
   localparam logic [3:0] CMD_S16       = 4'd1;
   localparam logic [3:0] CMD_S32       = 4'd2;
   localparam logic [3:0] CMD_S64       = 4'd3;
   localparam logic [3:0] CMD_U8        = 4'd4;
   localparam logic [3:0] CMD_U16       = 4'd5;
   localparam logic [3:0] CMD_U32       = 4'd6;
   localparam logic [3:0] CMD_BAD_FIRST = 4'd11;
   localparam logic [3:0] CMD_BAD_LAST  = 4'd15;

   localparam int RANDOM_ITEMS   = 75;
   localparam int CALM_ITEMS     = 20;
   localparam int SETTLE_CYCLES  = 20;
   localparam int QUIET_LIMIT    = 1000;

   logic             clock              = 1'b0;
   logic             reset              = 1'b1;
   logic             req_push           = 1'b0;
   logic [3:0]       req_command        = '0;
   logic [63:0]      req_value          = '0;
   logic             req_end_of_message = 1'b0;
   logic             rsp_pop            = 1'b0;
   logic             req_full;
   logic             rsp_empty;
   logic [7:0]       rsp_out_byte;
   logic             rsp_last_byte;
   logic [IDX_W-1:0] rsp_byte_index;
   logic             rsp_range_error;
   logic             rsp_message_overflow;
   int               mismatches;
   int               outstanding;

   bit idle_on  = 1'b1;
   int pop_hold = 0;
   int quiet    = 0;

   always #5ns clock = ~clock;

   typed_value_packer_core u_top (.*);

   typed_value_packer_checker u_checker (.*);

   // receiver stalls in random bursts
   always @(negedge clock) begin
      if (pop_hold > 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= $urandom_range(0, 6);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // end the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("typed_value_packer_core test failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // one input transfer, optionally after a gap; entered and left at a falling edge
   task automatic send(input logic [3:0] cmd, input logic [63:0] v, input logic eom);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 7);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push           <= 1'b1;
      req_command        <= cmd;
      req_value          <= v;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off the sender until every queued byte has come out
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // single pattern with exponents near the half and single limits
   function automatic logic [63:0] rand_single();
      logic [7:0]  e;
      logic [22:0] f;
      case ($urandom_range(0, 7))
         0:       e = 8'h00;
         1:       e = 8'hFF;
         2:       e = 8'($urandom_range(105, 118));
         3:       e = 8'($urandom_range(137, 150));
         default: e = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
         0:       f = '0;
         1:       f = '1;
         default: f = 23'($urandom);
      endcase
      return {32'($urandom), 1'($urandom), e, f};
   endfunction

   // double pattern with exponents near the edges
   function automatic logic [63:0] rand_double();
      logic [10:0] e;
      logic [51:0] f;
      case ($urandom_range(0, 7))
         0:       e = 11'h000;
         1:       e = 11'h7FF;
         2:       e = 11'($urandom_range(1, 2));
         3:       e = 11'h7FE;
         default: e = 11'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       f = '0;
         1:       f = '1;
         default: f = 52'({$urandom, $urandom});
      endcase
      return {1'($urandom), e, f};
   endfunction

   initial begin
      logic [3:0]  cmd;
      logic [63:0] v;
      logic        eom;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // integers: sign patterns and ignored upper bits
      send(CMD_S8, 64'hFFFF_FFFF_FFFF_FF80, 1'b0);
      send(CMD_S16, 64'h0123_4567_89AB_8001, 1'b0);
      send(CMD_S32, 64'hAAAA_AAAA_8000_0000, 1'b0);
      send(CMD_S64, 64'h8000_0000_0000_0001, 1'b1);
      send(CMD_U8, 64'h0000_0000_0000_0000, 1'b0);
      send(CMD_U16, 64'h5555_5555_5555_FFFF, 1'b0);
      send(CMD_U32, 64'h0000_0000_FFFF_FFFF, 1'b0);
      send(CMD_U64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      // half: zeros, infinity, nan, subnormal, exponent limits, fraction carry
      send(CMD_F16, 64'h0000_0000_0000_0000, 1'b0);
      send(CMD_F16, 64'h0000_0000_8000_0000, 1'b0);
      send(CMD_F16, 64'h0000_0000_7F80_0000, 1'b0);
      send(CMD_F16, 64'h0000_0000_FFC0_0001, 1'b0);
      send(CMD_F16, 64'h0000_0000_0000_0001, 1'b0);
      send(CMD_F16, 64'h0000_0000_4780_0000, 1'b0);
      send(CMD_F16, 64'h0000_0000_B800_0000, 1'b0);
      send(CMD_F16, 64'h0000_0000_477F_FFFF, 1'b0);
      send(CMD_F16, 64'hDEAD_BEEF_3880_0000, 1'b1);
      // single and double: normal, infinity or nan, subnormal
      send(CMD_F32, 64'h0000_0000_3F80_0001, 1'b0);
      send(CMD_F32, 64'h0000_0000_FF80_0000, 1'b0);
      send(CMD_F32, 64'h0000_0000_8000_0001, 1'b0);
      send(CMD_F64, 64'h3FF0_0000_0000_0001, 1'b0);
      send(CMD_F64, 64'h7FF8_0000_0000_0001, 1'b0);
      send(CMD_F64, 64'h8000_0000_0000_0001, 1'b0);
      // invalid codes emit nothing, end of message still clears the count
      send(CMD_BAD_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send(CMD_BAD_LAST, 64'h0, 1'b1);
      drain();

      // random mix, last stretch without idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS)
            idle_on <= 1'b0;
         if ($urandom_range(0, 2) == 0)
            cmd = 4'($urandom_range(CMD_F16, CMD_F64));
         else
            cmd = 4'($urandom_range(0, 15));
         if (cmd == CMD_F16 || cmd == CMD_F32)
            v = rand_single();
         else if (cmd == CMD_F64)
            v = rand_double();
         else
            v = {$urandom, $urandom};
         eom = ($urandom_range(0, 4) == 0);
         send(cmd, v, eom);
      end
      req_push <= 1'b0;

      // wait for the last bytes, then watch for strays
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("typed_value_packer_core test passed");
      end else begin
         $display("typed_value_packer_core test failed");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/tvp_pkg.sv
sv/tvp_front.sv
sv/tvp_queue.sv
sv/tvp_back.sv
sv/typed_value_packer_core.sv
bench/typed_value_packer_checker.sv
bench/typed_value_packer_core_tb.sv
